FILE: sv/command_header_deframer_assert.svh
// Assertion macros for the command header deframer.
// Assumes clk and rst are visible where a macro is used.
`ifndef COMMAND_HEADER_DEFRAMER_ASSERT_SVH
`define COMMAND_HEADER_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold on every clock edge outside reset
`define CHD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed in %m");

// Antecedent in one cycle implies consequent in the same cycle
`define CHD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

`else

`define CHD_ASSERT_ALWAYS(lbl, expr)
`define CHD_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

FILE: sv/chd_pkg.sv
// Shared types, codes and the opcode/length decode for the deframer.
// No dependencies.
package chd_pkg;

  // Parse position within a header or payload
  typedef enum logic [2:0] {
    PH_HLEN_HI,
    PH_HLEN_LO,
    PH_OPCODE,
    PH_ACK,
    PH_MLEN_HI,
    PH_MLEN_LO,
    PH_PAYLOAD
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DATA,
    KIND_FMT_ERR,
    KIND_LEN_ERR
  } kind_t;

  // Opcode characters
  localparam logic [7:0] OP_S = 8'h53;
  localparam logic [7:0] OP_B = 8'h42;
  localparam logic [7:0] OP_R = 8'h52;
  localparam logic [7:0] OP_C = 8'h43;
  localparam logic [7:0] OP_U = 8'h55;
  localparam logic [7:0] OP_F = 8'h46;

  localparam logic [15:0] MAX_BLOCK_RESET = 16'd4096;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  opcode;
    logic [7:0]  ack_code;
    logic        has_ack;
    logic [15:0] msg_len;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // Which optional fields follow the opcode
  typedef struct packed {
    logic ok;
    logic want_ack;
    logic want_length;
  } decode_t;

  function automatic decode_t decode_header(input logic [7:0] op, input logic [15:0] hl);
    decode_t d;
    d = '0;
    d.ok = 1'b1;
    unique case (op) inside
      OP_S, OP_U: begin
        if (hl == 16'd5) d.want_length = 1'b1;
        else if (hl == 16'd4) d.want_ack = 1'b1;
        else d.ok = 1'b0;
      end
      OP_B: begin
        if (hl == 16'd5) d.want_length = 1'b1;
        else d.ok = 1'b0;
      end
      OP_R: begin
        if (hl == 16'd5) d.want_length = 1'b1;
        else if (hl == 16'd6) begin
          d.want_ack    = 1'b1;
          d.want_length = 1'b1;
        end else if (hl == 16'd4) d.want_ack = 1'b1;
        else d.ok = 1'b0;
      end
      OP_C, OP_F: begin
        if (hl == 16'd3) d.ok = 1'b1;
        else if (hl == 16'd6) begin
          d.want_ack    = 1'b1;
          d.want_length = 1'b1;
        end else if (hl == 16'd4) d.want_ack = 1'b1;
        else d.ok = 1'b0;
      end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/chd_parser.sv
// Header parse state machine: consumes one byte per transfer, emits results.
// Depends on chd_pkg.
module chd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             step,       // byte transfer this cycle
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output chd_pkg::result_t res
);
  import chd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] block_limit;
  logic [15:0] header_length, header_length_next;
  logic [7:0]  current_opcode, current_opcode_next;
  logic [7:0]  current_ack, current_ack_next;
  logic        want_ack, want_ack_next;
  logic        want_length, want_length_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_left, bytes_left_next;

  decode_t     dec;
  logic        fin;
  logic [15:0] fin_len;
  logic        too_big;
  logic        len_zero;
  logic        final_byte;

  // Decode and header completion
  assign dec        = decode_header(in_byte, header_length);
  assign fin_len    = (phase == PH_MLEN_LO) ? {payload_length[15:8], in_byte} : 16'd0;
  assign too_big    = fin_len > block_limit;
  assign len_zero   = fin_len == 16'd0;
  assign final_byte = bytes_left[15:1] == 15'd0;
  assign fin = step && (((phase == PH_OPCODE) && dec.ok && !dec.want_ack && !dec.want_length)
                        || ((phase == PH_ACK) && !want_length)
                        || (phase == PH_MLEN_LO));

  // Next state
  always_comb begin
    phase_next          = phase;
    header_length_next  = header_length;
    current_opcode_next = current_opcode;
    current_ack_next    = current_ack;
    want_ack_next       = want_ack;
    want_length_next    = want_length;
    payload_length_next = payload_length;
    bytes_left_next     = bytes_left;
    if (step) begin
      unique case (phase)
        PH_HLEN_HI: begin
          header_length_next = {in_byte, 8'h00};
          phase_next         = PH_HLEN_LO;
        end
        PH_HLEN_LO: begin
          header_length_next = {header_length[15:8], in_byte};
          phase_next         = PH_OPCODE;
        end
        PH_OPCODE: begin
          current_opcode_next = in_byte;
          current_ack_next    = 8'h00;
          payload_length_next = 16'd0;
          bytes_left_next     = 16'd0;
          want_ack_next       = dec.want_ack;
          want_length_next    = dec.want_length;
          if (!dec.ok) phase_next = PH_HLEN_HI;
          else if (dec.want_ack) phase_next = PH_ACK;
          else if (dec.want_length) phase_next = PH_MLEN_HI;
        end
        PH_ACK: begin
          current_ack_next = in_byte;
          if (want_length) phase_next = PH_MLEN_HI;
        end
        PH_MLEN_HI: begin
          payload_length_next = {in_byte, 8'h00};
          phase_next          = PH_MLEN_LO;
        end
        PH_MLEN_LO: begin
          payload_length_next = fin_len;
        end
        PH_PAYLOAD: begin
          if (final_byte) begin
            bytes_left_next = 16'd0;
            phase_next      = PH_HLEN_HI;
          end else begin
            bytes_left_next = bytes_left - 16'd1;
          end
        end
        default: phase_next = PH_HLEN_HI;
      endcase
      // header complete: go to payload unless empty or oversized
      if (fin) begin
        if (too_big || len_zero) begin
          phase_next = PH_HLEN_HI;
        end else begin
          bytes_left_next = fin_len;
          phase_next      = PH_PAYLOAD;
        end
      end
    end
  end

  // Result for this transfer, built from the updated state
  always_comb begin
    res_valid     = 1'b0;
    res.kind      = KIND_HEADER;
    res.opcode    = current_opcode_next;
    res.ack_code  = current_ack_next;
    res.has_ack   = want_ack_next;
    res.msg_len   = payload_length_next;
    res.data_byte = 8'h00;
    res.last      = 1'b0;
    if (step) begin
      unique case (phase)
        PH_OPCODE: begin
          if (!dec.ok) begin
            res_valid = 1'b1;
            res.kind  = KIND_FMT_ERR;
            res.last  = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = in_byte;
          res.last      = final_byte;
        end
        default: res_valid = 1'b0;
      endcase
      if (fin) begin
        res_valid = 1'b1;
        res.kind  = too_big ? KIND_LEN_ERR : KIND_HEADER;
        res.last  = too_big || len_zero;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HLEN_HI;
      block_limit    <= MAX_BLOCK_RESET;
      header_length  <= 16'd0;
      current_opcode <= 8'h00;
      current_ack    <= 8'h00;
      want_ack       <= 1'b0;
      want_length    <= 1'b0;
      payload_length <= 16'd0;
      bytes_left     <= 16'd0;
    end else begin
      phase          <= phase_next;
      header_length  <= header_length_next;
      current_opcode <= current_opcode_next;
      current_ack    <= current_ack_next;
      want_ack       <= want_ack_next;
      want_length    <= want_length_next;
      payload_length <= payload_length_next;
      bytes_left     <= bytes_left_next;
      if (cfg_wr_en) block_limit <= cfg_wr_data;
    end
  end

endmodule

FILE: sv/chd_out_buf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on chd_pkg for the result type.
module chd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  chd_pkg::result_t push_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output chd_pkg::result_t out_data
);
  import chd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) skid_valid <= 1'b0;
      end else if (push && out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end
      if (!out_valid || pop) out_valid <= skid_valid || push;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!skid_valid && push && out_valid && !out_ready) skid_data <= push_data;
  end

endmodule

FILE: sv/command_header_deframer.sv
// Command header deframer: one received byte per transfer in, header,
// payload and error results out. Throughput is one byte per cycle while the
// skid register is empty; a result is registered into the output buffer and
// appears on m_axis from its result register. A two-entry output buffer keeps
// input flowing while a result waits. Synchronous reset: parser waits for a
// header length byte, block_limit returns to 4096, output buffer empties.
module command_header_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // block_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] opcode, [15:8] ack_code, [16] has_ack, [32:17] msg_len,
  // [40:33] data_byte, [47:41] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import chd_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign step = s_axis_tvalid && s_axis_tready;

  chd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .in_byte     (s_axis_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  chd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // Output packing
  assign m_axis_tdata = {7'd0, out_res.data_byte, out_res.msg_len, out_res.has_ack,
                         out_res.ack_code, out_res.opcode};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.kind;

`include "command_header_deframer_assert.svh"

  // Input stalls only while both buffer entries are full
  `CHD_ASSERT_IMPL(a_stall_has_output, !s_axis_tready, m_axis_tvalid)
  // Results only arise from an accepted byte
  `CHD_ASSERT_IMPL(a_result_needs_byte, res_valid, step)
  // Error results always close the message
  `CHD_ASSERT_IMPL(a_error_is_last,
    m_axis_tvalid && (m_axis_tuser == KIND_FMT_ERR || m_axis_tuser == KIND_LEN_ERR),
    m_axis_tlast)
  // A header followed by payload has a nonzero length
  `CHD_ASSERT_IMPL(a_open_header_len,
    m_axis_tvalid && m_axis_tuser == KIND_HEADER && !m_axis_tlast,
    m_axis_tdata[32:17] != 16'd0)

endmodule

FILE: test/command_header_deframer_tb.sv
// Self-checking testbench for command_header_deframer: directed and random header/payload
// byte streams under varied backpressure, checked against an in-bench parser.
// Depends on chd_pkg (sv/chd_pkg.sv) and the deframer RTL.
module command_header_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned PHASE_BYTES = 65;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned MAX_REPORTS = 10;

  // DUT connections
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // opcode, ack_code, has_ack, msg_len, data_byte, pad
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;   // kind

  // Bytes waiting to be sent, and results the parser says must come out
  logic [7:0]  tx_bytes[$];
  result_t     due_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned queued = 0;

  // Parser state mirrored in the bench
  phase_t      rx_phase = PH_HLEN_HI;
  logic [15:0] hdr_len = '0;
  logic [7:0]  cur_op = '0;
  logic [7:0]  cur_ack = '0;
  logic        need_ack = 1'b0;
  logic        need_len = 1'b0;
  logic [15:0] pay_len = '0;
  logic [15:0] remaining = '0;
  logic [15:0] max_block = MAX_BLOCK_RESET;

  // Legal opcode/header-length pairs
  logic [7:0]  legal_op[14] = '{OP_S, OP_S, OP_B, OP_R, OP_R, OP_R, OP_C, OP_C, OP_C,
                                 OP_U, OP_U, OP_F, OP_F, OP_F};
  logic [15:0] legal_hl[14] = '{16'd5, 16'd4, 16'd5, 16'd5, 16'd6, 16'd4, 16'd3, 16'd6,
                                 16'd4, 16'd5, 16'd4, 16'd3, 16'd6, 16'd4};

  result_t got;
  result_t want;

  command_header_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Returns {ok, ack follows, length follows} for an opcode and header length
  function automatic logic [2:0] header_fields(input logic [7:0] op, input logic [15:0] hl);
    case (op) inside
      OP_S, OP_U: begin
        if (hl == 16'd5) return 3'b101;
        if (hl == 16'd4) return 3'b110;
      end
      OP_B: begin
        if (hl == 16'd5) return 3'b101;
      end
      OP_R: begin
        if (hl == 16'd5) return 3'b101;
        if (hl == 16'd6) return 3'b111;
        if (hl == 16'd4) return 3'b110;
      end
      OP_C, OP_F: begin
        if (hl == 16'd3) return 3'b100;
        if (hl == 16'd6) return 3'b111;
        if (hl == 16'd4) return 3'b110;
      end
      default: ;
    endcase
    return 3'b000;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] b, input logic l);
    result_t r;
    r.kind      = k;
    r.opcode    = cur_op;
    r.ack_code  = cur_ack;
    r.has_ack   = need_ack;
    r.msg_len   = pay_len;
    r.data_byte = b;
    r.last      = l;
    return r;
  endfunction

  // Header is complete: oversize error, header with no payload, or start payload
  task automatic close_header();
    if (pay_len > max_block) begin
      due_results.push_back(make_result(KIND_LEN_ERR, 8'h00, 1'b1));
      rx_phase = PH_HLEN_HI;
    end else if (pay_len == 16'd0) begin
      due_results.push_back(make_result(KIND_HEADER, 8'h00, 1'b1));
      rx_phase = PH_HLEN_HI;
    end else begin
      due_results.push_back(make_result(KIND_HEADER, 8'h00, 1'b0));
      remaining = pay_len;
      rx_phase = PH_PAYLOAD;
    end
  endtask

  // Advance the mirrored parser by one accepted byte
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [2:0] f;
    case (rx_phase)
      PH_HLEN_HI: begin
        hdr_len = {b, 8'h00};
        rx_phase = PH_HLEN_LO;
      end
      PH_HLEN_LO: begin
        hdr_len[7:0] = b;
        rx_phase = PH_OPCODE;
      end
      PH_OPCODE: begin
        cur_op = b;
        cur_ack = '0;
        pay_len = '0;
        remaining = '0;
        f = header_fields(b, hdr_len);
        need_ack = f[1];
        need_len = f[0];
        if (!f[2]) begin
          need_ack = 1'b0;
          need_len = 1'b0;
          due_results.push_back(make_result(KIND_FMT_ERR, 8'h00, 1'b1));
          rx_phase = PH_HLEN_HI;
        end else if (need_ack) rx_phase = PH_ACK;
        else if (need_len) rx_phase = PH_MLEN_HI;
        else close_header();
      end
      PH_ACK: begin
        cur_ack = b;
        if (need_len) rx_phase = PH_MLEN_HI;
        else close_header();
      end
      PH_MLEN_HI: begin
        pay_len = {b, 8'h00};
        rx_phase = PH_MLEN_LO;
      end
      PH_MLEN_LO: begin
        pay_len[7:0] = b;
        close_header();
      end
      PH_PAYLOAD: begin
        if (remaining <= 16'd1) begin
          due_results.push_back(make_result(KIND_DATA, b, 1'b1));
          remaining = '0;
          rx_phase = PH_HLEN_HI;
        end else begin
          due_results.push_back(make_result(KIND_DATA, b, 1'b0));
          remaining = remaining - 16'd1;
        end
      end
      default: rx_phase = PH_HLEN_HI;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued++;
  endtask

  // Queue one header and, when it is legal and in range, its payload
  task automatic queue_frame(input logic [7:0] op, input logic [15:0] hl,
                             input logic [7:0] ack, input logic [15:0] mlen);
    logic [2:0]  f;
    int unsigned n;
    f = header_fields(op, hl);
    n = 0;
    push_byte(hl[15:8]);
    push_byte(hl[7:0]);
    push_byte(op);
    if (f[2]) begin
      if (f[1]) push_byte(ack);
      if (f[0]) begin
        push_byte(mlen[15:8]);
        push_byte(mlen[7:0]);
        if (mlen != 16'd0 && mlen <= max_block) n = 32'(mlen);
      end
    end
    repeat (n) push_byte(8'($urandom_range(255)));
  endtask

  // Payload length: mostly short, with zero, boundary and oversize cases
  function automatic logic [15:0] pick_msg_len();
    int unsigned top;
    top = (max_block < 16'd12) ? 32'(max_block) : 12;
    case ($urandom_range(19))
      0: return 16'd0;
      1: return (max_block < 16'hFFFF) ? max_block + 16'd1 : 16'd0;
      2: return (max_block < 16'hFFFF) ? 16'($urandom_range(65535, max_block + 1)) : 16'd1;
      3: return (max_block <= 16'd48) ? max_block : 16'd1;
      default: return 16'($urandom_range(top, 1));
    endcase
  endfunction

  // Mostly well-formed frames with random content, the rest malformed headers
  task automatic queue_random_frame();
    int unsigned sel;
    logic [7:0]  op;
    logic [15:0] hl;
    logic [2:0]  f;
    if ($urandom_range(99) < 85) begin
      sel = $urandom_range(13);
      queue_frame(legal_op[sel], legal_hl[sel], 8'($urandom_range(255)), pick_msg_len());
    end else begin
      op = 8'($urandom_range(255));
      hl = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(7));
      f = header_fields(op, hl);
      if (f[2]) hl = 16'd7;
      queue_frame(op, hl, 8'h00, 16'd0);
    end
  endtask

  // Hold until every byte is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_max_block(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    max_block = v;
  endtask

  task automatic note_mismatch(input string what, input result_t exp_r, input result_t act_r,
                               input logic [6:0] pad);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0d: %s exp kind=%0d op=%h ack=%h has_ack=%b len=%h data=%h last=%b",
               cycles, what, exp_r.kind, exp_r.opcode, exp_r.ack_code, exp_r.has_ack,
               exp_r.msg_len, exp_r.data_byte, exp_r.last);
      $display("%0d: %s act kind=%0d op=%h ack=%h has_ack=%b len=%h data=%h last=%b pad=%h",
               cycles, what, act_r.kind, act_r.opcode, act_r.ack_code, act_r.has_ack,
               act_r.msg_len, act_r.data_byte, act_r.last, pad);
    end
  endtask

  // Sender: predict on each accepted transfer, then offer the next byte
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = kind_t'(m_axis_tuser);
        got.opcode    = m_axis_tdata[7:0];
        got.ack_code  = m_axis_tdata[15:8];
        got.has_ack   = m_axis_tdata[16];
        got.msg_len   = m_axis_tdata[32:17];
        got.data_byte = m_axis_tdata[40:33];
        got.last      = m_axis_tlast;
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got, m_axis_tdata[47:41]);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.opcode !== want.opcode ||
              got.ack_code !== want.ack_code || got.has_ack !== want.has_ack ||
              got.msg_len !== want.msg_len || got.data_byte !== want.data_byte ||
              got.last !== want.last || m_axis_tdata[47:41] !== 7'd0)
            note_mismatch("mismatch", want, got, m_axis_tdata[47:41]);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [15:0] cfg_plan[NUM_PHASES];
    cfg_plan = '{MAX_BLOCK_RESET, 16'd1, 16'hFFFF, MAX_BLOCK_RESET, 16'd12,
                 16'($urandom_range(65535, 1)), 16'd3, 16'd200};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: no-payload header, length only, ack+length, bad opcode, bad
    // length, oversize length, zero length
    queue_frame(OP_C, 16'd3, 8'h00, 16'd0);
    queue_frame(OP_S, 16'd5, 8'h00, 16'd2);
    queue_frame(OP_R, 16'd6, 8'hFF, 16'd1);
    queue_frame(8'h58, 16'd5, 8'h00, 16'd0);
    queue_frame(OP_S, 16'hFFFF, 8'h00, 16'd0);
    queue_frame(OP_U, 16'd5, 8'h00, 16'h1001);
    queue_frame(OP_U, 16'd5, 8'h00, 16'd0);
    drain();

    // Random phases, each with a limit from cfg_plan and an idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) write_max_block(cfg_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      queued = 0;
      while (queued < PHASE_BYTES) queue_random_frame();
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (due_results.size() != 0) errors++;
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: command_header_deframer.f
+incdir+sv
sv/chd_pkg.sv
sv/chd_parser.sv
sv/chd_out_buf.sv
sv/command_header_deframer.sv
test/command_header_deframer_tb.sv
